// ===== sv/pild_pkg.sv =====
`timescale 1ns / 1ps

package pild_pkg;

    localparam int POS_BITS = 8;
    localparam int OP_BITS  = 2;
    localparam int VAL_BITS = 32;
    localparam int CNT_BITS = 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                get;
        logic                ins;
        logic                del;
        logic [POS_BITS-1:0] pos_idx;   // 0-based position
    } cmd_t;

endpackage

// ===== sv/positional_insert_delete_list.sv =====
`timescale 1ns / 1ps

// Positional insert/delete list.
// Slave channel s_*: one request beat = op, 1-based position, value.
//   op get reads an entry, insert places value before position, delete
//   removes the entry at position. Out-of-range or full requests fail.
// Master channel m_*: one result beat per request = ok, read_value, count.
// Entries live in a row of DEPTH cells; an insert or delete moves every
// affected cell by one place at once, so one beat per cycle is sustained
// while m_tready stays high. A request passes the request register, the
// cell update with group OR of the read select, and the final OR into the
// output register.
// Reset (aresetn low, synchronous) empties the list and drops all beats
// in flight; entry words are not cleared.
// When m_tready is low the output register holds its beat, the group
// stage and then the request stage stall, and s_tready drops once the
// request register is occupied; no beat is lost.

module positional_insert_delete_list import pild_pkg::*; #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // op[1:0], position[9:2], value[41:10], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // ok[0], read_value[32:1], count[40:33], zero fill
);

    localparam int LEN_BITS = $clog2(DEPTH + 1);
    localparam int IDX_BITS = (($clog2(DEPTH) > POS_BITS) ? $clog2(DEPTH) : POS_BITS) + 1;
    localparam int CW       = LEN_BITS + POS_BITS + 1;
    localparam int GROUP    = 16;
    localparam int NG       = (DEPTH + GROUP - 1) / GROUP;

    // request stage
    logic                 r_vld_reg;
    logic [OP_BITS-1:0]   r_op_reg;
    logic [POS_BITS-1:0]  r_pos_reg;
    logic [VAL_BITS-1:0]  r_val_reg;
    // group stage
    logic                 g_vld_reg;
    logic                 g_ok_reg;
    logic [LEN_BITS-1:0]  g_len_reg;
    logic [WORD_BITS-1:0] g_grp_reg [NG];
    logic [WORD_BITS-1:0] g_grp_next [NG];
    // output stage
    logic                 o_vld_reg;
    logic                 o_ok_reg;
    logic [VAL_BITS-1:0]  o_rd_reg;
    logic [VAL_BITS-1:0]  o_rd_next;
    logic [CNT_BITS-1:0]  o_cnt_reg;

    logic [LEN_BITS-1:0]  len_reg;
    logic [LEN_BITS-1:0]  len_next;

    logic o_can, g_can, adv_r;
    logic get_ok, ins_ok, del_ok, r_ok;
    logic [CW-1:0] pos_w, len_w;
    logic [63:0] val64;
    logic [WORD_BITS-1:0] ins_word;
    cmd_t cmd;

    logic [WORD_BITS-1:0] words     [DEPTH];
    logic [WORD_BITS-1:0] sel_words [DEPTH];
    logic [DEPTH-1:0]     sel_vec;
    logic [WORD_BITS-1:0] rd_word;
    logic [63:0]          rd64;
    logic [LEN_BITS+CNT_BITS-1:0] len_ext;

    assign o_can    = !o_vld_reg || m_tready;
    assign g_can    = !g_vld_reg || o_can;
    assign adv_r    = r_vld_reg && g_can;
    assign s_tready = !r_vld_reg || g_can;

    assign pos_w = CW'(r_pos_reg);
    assign len_w = CW'(len_reg);

    always_comb begin
        get_ok = 1'b0;
        ins_ok = 1'b0;
        del_ok = 1'b0;
        case (op_t'(r_op_reg))
            OP_GET: begin
                get_ok = (r_pos_reg != '0) && (pos_w <= len_w);
            end
            OP_INSERT: begin
                ins_ok = (len_w < CW'(DEPTH)) && (r_pos_reg != '0) &&
                         (pos_w <= len_w + CW'(1));
            end
            OP_DELETE: begin
                del_ok = (r_pos_reg != '0) && (pos_w <= len_w);
            end
            default: begin
            end
        endcase
    end

    assign r_ok = get_ok || ins_ok || del_ok;

    assign cmd.get     = adv_r && get_ok;
    assign cmd.ins     = adv_r && ins_ok;
    assign cmd.del     = adv_r && del_ok;
    assign cmd.pos_idx = r_pos_reg - POS_BITS'(1);

    assign val64    = 64'($signed(r_val_reg));
    assign ins_word = val64[WORD_BITS-1:0];

    always_comb begin
        len_next = len_reg;
        if (cmd.ins) begin
            len_next = len_reg + LEN_BITS'(1);
        end else if (cmd.del) begin
            len_next = len_reg - LEN_BITS'(1);
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [WORD_BITS-1:0] left_w, right_w;
            if (i == 0) begin : g_first
                assign left_w = ins_word;
            end else begin : g_mid_l
                assign left_w = words[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_w = words[i];
            end else begin : g_mid_r
                assign right_w = words[i+1];
            end
            pild_cell #(
                .WORD_BITS (WORD_BITS),
                .IDX_BITS  (IDX_BITS),
                .INDEX     (i)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .ins_word   (ins_word),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (words[i]),
                .sel        (sel_vec[i]),
                .sel_word   (sel_words[i])
            );
        end
    endgenerate

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            g_grp_next[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < DEPTH) begin
                    g_grp_next[g] = g_grp_next[g] | sel_words[g * GROUP + k];
                end
            end
        end
    end

    always_comb begin
        rd_word = '0;
        for (int g = 0; g < NG; g++) begin
            rd_word = rd_word | g_grp_reg[g];
        end
    end

    assign rd64      = 64'($signed(rd_word));
    assign o_rd_next = rd64[VAL_BITS-1:0];
    assign len_ext   = {{CNT_BITS{1'b0}}, g_len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            len_reg   <= '0;
        end else begin
            len_reg <= len_next;
            if (s_tready) begin
                r_vld_reg <= s_tvalid;
            end
            if (g_can) begin
                g_vld_reg <= r_vld_reg;
            end
            if (o_can) begin
                o_vld_reg <= g_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            r_op_reg  <= s_tdata[1:0];
            r_pos_reg <= s_tdata[9:2];
            r_val_reg <= s_tdata[41:10];
        end
        if (adv_r) begin
            g_ok_reg  <= r_ok;
            g_len_reg <= len_next;
            g_grp_reg <= g_grp_next;
        end
        if (o_can && g_vld_reg) begin
            o_ok_reg  <= g_ok_reg;
            o_rd_reg  <= o_rd_next;
            o_cnt_reg <= len_ext[CNT_BITS-1:0];
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {7'd0, o_cnt_reg, o_rd_reg, o_ok_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_BITS'(DEPTH))
        else $error("list length above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_vec))
        else $error("more than one cell selected for read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (r_vld_reg && !r_ok) |=> (len_reg == $past(len_reg)))
        else $error("rejected request changed the length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!r_vld_reg || !g_can) |=> (len_reg == $past(len_reg)))
        else $error("length changed without an advancing request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == '0))
        else $error("failed request carries read data");

endmodule

// ===== sv/pild_cell.sv =====
`timescale 1ns / 1ps

module pild_cell import pild_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int IDX_BITS  = 9,
    parameter int INDEX     = 0
) (
    input  logic                 aclk,
    input  cmd_t                 cmd,
    input  logic [WORD_BITS-1:0] ins_word,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    output logic [WORD_BITS-1:0] word,
    output logic                 sel,
    output logic [WORD_BITS-1:0] sel_word
);

    localparam logic [IDX_BITS-1:0] IDX = IDX_BITS'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [IDX_BITS-1:0]  q;

    assign q = {{(IDX_BITS-POS_BITS){1'b0}}, cmd.pos_idx};

    always_comb begin
        word_next = word_reg;
        if (cmd.ins) begin
            if (IDX > q) begin
                word_next = left_word;
            end else if (IDX == q) begin
                word_next = ins_word;
            end
        end else if (cmd.del && (IDX >= q)) begin
            word_next = right_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel      = cmd.get && (IDX == q);
    assign sel_word = sel ? word_reg : '0;

endmodule
